// File: src/mfs_pkg.sv
// Shared types and constants for the maximum frequency stack.
package mfs_pkg;

  localparam int VALUE_W     = 8;
  localparam int CAPACITY    = 64;
  localparam int VALUE_SPACE = 1 << VALUE_W;
  localparam int LVL_W       = $clog2(CAPACITY + 1);
  localparam int OCC_W       = $clog2(CAPACITY + 1);
  localparam int STATUS_W    = 2;

  typedef enum logic {
    OP_PUSH = 1'b0,
    OP_POP  = 1'b1
  } mfs_op_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } mfs_status_t;

  typedef enum logic {
    S_IDLE = 1'b0,
    S_PUSH = 1'b1
  } mfs_state_t;

  // Broadcast to every cell of the entry chain
  typedef struct packed {
    logic               pop;
    logic [LVL_W-1:0]   max_level;
    logic [VALUE_W-1:0] push_value;
    logic [LVL_W-1:0]   push_level;
  } mfs_ctrl_t;

endpackage

// File: src/mfs_cell.sv
// One entry slot of the chain: holds a value, its level and a live flag.
module mfs_cell (
  input  logic                      clk,
  input  logic                      rst_n,
  input  mfs_pkg::mfs_ctrl_t        ctrl,
  input  logic                      push_sel,
  input  logic                      any_above,
  input  logic [mfs_pkg::VALUE_W-1:0] nb_value,
  input  logic [mfs_pkg::LVL_W-1:0] nb_level,
  input  logic                      nb_live,
  output logic [mfs_pkg::VALUE_W-1:0] value,
  output logic [mfs_pkg::LVL_W-1:0] level,
  output logic                      live,
  output logic                      match,
  output logic                      pick
);
  import mfs_pkg::*;

  logic [VALUE_W-1:0] value_r, value_nxt;
  logic [LVL_W-1:0]   level_r, level_nxt;
  logic               live_r, live_nxt;
  logic               shift;

  assign match = live_r && (level_r == ctrl.max_level);
  assign pick  = match && !any_above;
  // this slot and every one above the removed entry close up
  assign shift = ctrl.pop && !any_above;

  always_comb begin
    value_nxt = value_r;
    level_nxt = level_r;
    live_nxt  = live_r;
    if (push_sel) begin
      value_nxt = ctrl.push_value;
      level_nxt = ctrl.push_level;
      live_nxt  = 1'b1;
    end else if (shift) begin
      value_nxt = nb_value;
      level_nxt = nb_level;
      live_nxt  = nb_live;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      live_r <= 1'b0;
    end else begin
      live_r <= live_nxt;
    end
  end

  always_ff @(posedge clk) begin
    value_r <= value_nxt;
    level_r <= level_nxt;
  end

  assign value = value_r;
  assign level = level_r;
  assign live  = live_r;

endmodule

// File: src/mfs_count_ram.sv
// Per-value occurrence counts: one-port-write memory with reset-cleared valid bits.
module mfs_count_ram (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic [mfs_pkg::VALUE_W-1:0] rd_addr,
  output logic [mfs_pkg::LVL_W-1:0]   rd_data,
  input  logic                        wr_en,
  input  logic [mfs_pkg::VALUE_W-1:0] wr_addr,
  input  logic [mfs_pkg::LVL_W-1:0]   wr_data
);
  import mfs_pkg::*;

  logic [LVL_W-1:0]       mem [VALUE_SPACE];
  logic [VALUE_SPACE-1:0] vld_r;
  logic [LVL_W-1:0]       rd_data_r;
  logic                   rd_vld_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data_r <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r    <= '0;
      rd_vld_r <= 1'b0;
    end else begin
      rd_vld_r <= vld_r[rd_addr];
      if (wr_en) begin
        vld_r[wr_addr] <= 1'b1;
      end
    end
  end

  // a never-written count reads as zero
  assign rd_data = rd_vld_r ? rd_data_r : '0;

endmodule

// File: src/max_frequency_stack_unit.sv
// Top level of the maximum frequency stack: request handling, count memory and entry chain.
//
//  channel | dir | handshake               | payload
//  --------+-----+-------------------------+-----------------------------------------------
//  in_     | in  | in_tvalid / in_tready   | tuser[0] op, tdata[7:0] value
//  out_    | out | out_tvalid / out_tready | tdata[7:0] popped_value, tuser[1:0] status
//
//  A push reads the value's count from the count memory in the accept cycle and
//  writes it back, with the new entry, in the next one.
//  A pop, and any failed request, completes in the accept cycle: the entry chain finds
//  the newest entry at the maximum level and closes up behind it in one step.
//  Reset clears the count valid bits, the chain's live flags and the control at once;
//  no clearing sweep, requests are taken from the first cycle after reset.
//  A result waits in the output register; a new request is taken while that result
//  is being taken, and held off while it stalls.
module max_frequency_stack_unit (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_tvalid,
  output logic                         in_tready,
  input  logic [mfs_pkg::VALUE_W-1:0]  in_tdata,   // [7:0] value
  input  logic                         in_tuser,   // [0] op
  output logic                         out_tvalid,
  input  logic                         out_tready,
  output logic [mfs_pkg::VALUE_W-1:0]  out_tdata,  // [7:0] popped_value
  output logic [mfs_pkg::STATUS_W-1:0] out_tuser   // [1:0] status
);
  import mfs_pkg::*;

  mfs_state_t         state_r, state_nxt;
  logic [OCC_W-1:0]   occ_r, occ_nxt;
  logic [LVL_W-1:0]   max_level_r, max_level_nxt;
  logic [VALUE_W-1:0] push_value_r, push_value_nxt;

  logic                out_valid_r, out_valid_nxt;
  logic [VALUE_W-1:0]  out_data_r, out_data_nxt;
  mfs_status_t         out_status_r, out_status_nxt;

  logic accept, is_pop, is_empty, is_full, pop_go, remains;
  logic [LVL_W-1:0] rd_count, push_level;

  logic               ram_wr_en;
  logic [VALUE_W-1:0] ram_wr_addr;
  logic [LVL_W-1:0]   ram_wr_data;

  mfs_ctrl_t ctrl;

  logic [VALUE_W-1:0] cell_value [CAPACITY];
  logic [LVL_W-1:0]   cell_level [CAPACITY];
  logic [CAPACITY-1:0] cell_live, match_vec, pick_vec, any_above, push_sel;
  logic [VALUE_W-1:0] pop_value;

  // take a request only between items, with the output register free or draining
  assign in_tready = (state_r == S_IDLE) && (!out_valid_r || out_tready);
  assign accept    = in_tvalid && in_tready;
  assign is_pop    = (in_tuser == OP_POP);
  assign is_empty  = (occ_r == '0);
  assign is_full   = (occ_r == OCC_W'(CAPACITY));
  assign pop_go    = accept && is_pop && !is_empty;

  assign push_level = LVL_W'(rd_count + 1'b1);

  // count memory: read on push accept, write on push completion or pop
  mfs_count_ram u_count_ram (
    .clk     (clk),
    .rst_n   (rst_n),
    .rd_addr (in_tdata),
    .rd_data (rd_count),
    .wr_en   (ram_wr_en),
    .wr_addr (ram_wr_addr),
    .wr_data (ram_wr_data)
  );

  always_comb begin
    ctrl.pop        = pop_go;
    ctrl.max_level  = max_level_r;
    ctrl.push_value = push_value_r;
    ctrl.push_level = push_level;
  end

  // entry chain: slot 0 is the oldest entry, new entries land at the occupancy index
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic [VALUE_W-1:0] nb_value;
    logic [LVL_W-1:0]   nb_level;
    logic               nb_live;

    if (i == CAPACITY - 1) begin : g_top
      assign nb_value     = '0;
      assign nb_level     = '0;
      assign nb_live      = 1'b0;
      assign any_above[i] = 1'b0;
    end else begin : g_mid
      assign nb_value     = cell_value[i+1];
      assign nb_level     = cell_level[i+1];
      assign nb_live      = cell_live[i+1];
      assign any_above[i] = |match_vec[CAPACITY-1:i+1];
    end

    assign push_sel[i] = (state_r == S_PUSH) && (occ_r == OCC_W'(i));

    mfs_cell u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .ctrl      (ctrl),
      .push_sel  (push_sel[i]),
      .any_above (any_above[i]),
      .nb_value  (nb_value),
      .nb_level  (nb_level),
      .nb_live   (nb_live),
      .value     (cell_value[i]),
      .level     (cell_level[i]),
      .live      (cell_live[i]),
      .match     (match_vec[i]),
      .pick      (pick_vec[i])
    );
  end

  // select the value of the entry being removed
  always_comb begin
    pop_value = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      pop_value = pop_value | (cell_value[i] & {VALUE_W{pick_vec[i]}});
    end
  end

  // another entry stays at the maximum level when a match has one above it
  assign remains = |(match_vec & any_above);

  always_comb begin
    state_nxt      = state_r;
    occ_nxt        = occ_r;
    max_level_nxt  = max_level_r;
    push_value_nxt = push_value_r;
    out_valid_nxt  = out_valid_r && !out_tready;
    out_data_nxt   = out_data_r;
    out_status_nxt = out_status_r;
    ram_wr_en      = 1'b0;
    ram_wr_addr    = push_value_r;
    ram_wr_data    = push_level;

    case (state_r)
      S_IDLE: begin
        if (accept) begin
          push_value_nxt = in_tdata;
          out_data_nxt   = '0;
          out_status_nxt = ST_OK;
          if (is_pop) begin
            out_valid_nxt = 1'b1;
            if (is_empty) begin
              out_status_nxt = ST_EMPTY;
            end else begin
              // the removed entry sat at the top level, so its value's count was max_level
              out_data_nxt = pop_value;
              ram_wr_en    = 1'b1;
              ram_wr_addr  = pop_value;
              ram_wr_data  = LVL_W'(max_level_r - 1'b1);
              occ_nxt      = OCC_W'(occ_r - 1'b1);
              if (!remains) begin
                max_level_nxt = LVL_W'(max_level_r - 1'b1);
              end
            end
          end else if (is_full) begin
            out_valid_nxt  = 1'b1;
            out_status_nxt = ST_FULL;
          end else begin
            state_nxt = S_PUSH;
          end
        end
      end
      S_PUSH: begin
        // write back the raised count and place the entry
        ram_wr_en      = 1'b1;
        occ_nxt        = OCC_W'(occ_r + 1'b1);
        if (push_level > max_level_r) begin
          max_level_nxt = push_level;
        end
        out_valid_nxt  = 1'b1;
        out_data_nxt   = '0;
        out_status_nxt = ST_OK;
        state_nxt      = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      occ_r       <= '0;
      max_level_r <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      occ_r       <= occ_nxt;
      max_level_r <= max_level_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    push_value_r <= push_value_nxt;
    out_data_r   <= out_data_nxt;
    out_status_r <= out_status_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_status_r;

endmodule

// File: tb/sv/max_frequency_stack_unit_tb.sv
// Self-checking testbench for the maximum frequency stack: push/pop requests against a predictor.
module max_frequency_stack_unit_tb;
  import mfs_pkg::*;

  localparam int CLK_HALF    = 4;
  localparam int HOLD_CYCLES = 300;   // long receiver hold-off for the pressure test
  localparam int DRAIN_LIMIT = 5000;  // cycles allowed for the last results to arrive
  localparam int MAX_REPORTS = 10;

  // One result of the stack, field by field
  typedef struct packed {
    logic [VALUE_W-1:0] popped_value;
    mfs_status_t        status;
  } stack_result_t;

  logic                clk;
  logic                rst_n;
  logic                in_tvalid;
  logic                in_tready;
  logic [VALUE_W-1:0]  in_tdata;   // [7:0] value
  logic                in_tuser;   // [0] op
  logic                out_tvalid;
  logic                out_tready;
  logic [VALUE_W-1:0]  out_tdata;  // [7:0] popped_value
  logic [STATUS_W-1:0] out_tuser;  // [1:0] status

  // Predictor state: per-value counts and the live entries in push order
  logic [LVL_W-1:0]   freq_of [VALUE_SPACE];
  logic [VALUE_W-1:0] slot_value [$];
  logic [LVL_W-1:0]   slot_level [$];
  logic [LVL_W-1:0]   top_level;

  stack_result_t pending_results [$];
  int            mismatch_count;
  bit            gaps_on;
  bit            stalls_on;
  bit            hold_request;

  max_frequency_stack_unit DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  initial begin
    clk = 1'b0;
    forever #CLK_HALF clk = ~clk;
  end

  // Work out the result of one accepted request and advance the predictor state.
  function automatic stack_result_t predict_stack_result(mfs_op_t op, logic [VALUE_W-1:0] value);
    stack_result_t    res;
    int               pick;
    bit               found;
    bit               remains;
    logic [LVL_W-1:0] lvl;
    logic [LVL_W-1:0] highest;
    logic [VALUE_W-1:0] v;
    res.popped_value = '0;
    res.status       = ST_OK;
    if (op == OP_PUSH) begin
      if (slot_value.size() >= CAPACITY) begin
        res.status = ST_FULL;
      end else begin
        lvl = freq_of[value] + 1'b1;
        freq_of[value] = lvl;
        slot_value.insert(slot_value.size(), value);
        slot_level.insert(slot_level.size(), lvl);
        if (lvl > top_level) top_level = lvl;
      end
    end else if (slot_value.size() == 0) begin
      res.status = ST_EMPTY;
    end else begin
      // newest entry at the top level; fall back to the newest entry overall
      pick  = slot_value.size() - 1;
      found = 1'b0;
      for (int i = slot_value.size() - 1; i >= 0; i--) begin
        if (slot_level[i] == top_level) begin
          pick  = i;
          found = 1'b1;
          break;
        end
      end
      v = slot_value[pick];
      if (freq_of[v] > 0) freq_of[v] = freq_of[v] - 1'b1;
      slot_value.delete(pick);
      slot_level.delete(pick);
      remains = 1'b0;
      highest = '0;
      foreach (slot_level[i]) begin
        if (slot_level[i] == top_level) remains = 1'b1;
        if (slot_level[i] > highest) highest = slot_level[i];
      end
      if (found) begin
        if (!remains && top_level > 0) top_level = top_level - 1'b1;
      end else begin
        top_level = highest;
      end
      res.popped_value = v;
    end
    return res;
  endfunction

  // Offer one item, optionally after a random gap, and hold it until it is taken.
  task automatic send_request(input mfs_op_t op, input logic [VALUE_W-1:0] value);
    int gap;
    if (gaps_on && $urandom_range(0, 4) == 0) begin
      gap = $urandom_range(1, 15);
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= op;
    in_tdata  <= value;
    do @(posedge clk); while (!in_tready);
    pending_results.insert(pending_results.size(), predict_stack_result(op, value));
  endtask

  // Draw a value: mostly from a small pool so that counts climb, sometimes anything.
  function automatic logic [VALUE_W-1:0] draw_value(logic [VALUE_W-1:0] pool [4]);
    if ($urandom_range(0, 9) < 7) return pool[$urandom_range(0, 3)];
    return VALUE_W'($urandom_range(0, VALUE_SPACE - 1));
  endfunction

  // One random request; push_pct sets the chance of a push in percent.
  task automatic random_request(input int push_pct, input logic [VALUE_W-1:0] pool [4]);
    if ($urandom_range(0, 99) < push_pct) send_request(OP_PUSH, draw_value(pool));
    else send_request(OP_POP, VALUE_W'($urandom_range(0, VALUE_SPACE - 1)));
  endtask

  task automatic new_pool(output logic [VALUE_W-1:0] pool [4]);
    foreach (pool[i]) pool[i] = VALUE_W'($urandom_range(0, VALUE_SPACE - 1));
  endtask

  // Extremes of the value, ties within a level broken by recency, pop on empty.
  task automatic test_directed();
    send_request(OP_POP, 8'hFF);
    send_request(OP_PUSH, 8'h00);
    send_request(OP_PUSH, 8'hFF);
    send_request(OP_PUSH, 8'h00);
    send_request(OP_PUSH, 8'h00);
    send_request(OP_PUSH, 8'hFF);
    send_request(OP_PUSH, 8'hAA);
    send_request(OP_PUSH, 8'h55);
    repeat (7) send_request(OP_POP, 8'h00);
    send_request(OP_POP, 8'h5A);
  endtask

  // Fill to capacity, push on the full store, then drain past empty.
  task automatic test_fill_and_drain();
    logic [VALUE_W-1:0] pool [4];
    new_pool(pool);
    repeat (CAPACITY) send_request(OP_PUSH, pool[$urandom_range(0, 2)]);
    send_request(OP_PUSH, 8'hFF);
    send_request(OP_PUSH, VALUE_W'($urandom_range(0, VALUE_SPACE - 1)));
    repeat (CAPACITY + 1) send_request(OP_POP, VALUE_W'($urandom_range(0, VALUE_SPACE - 1)));
  endtask

  // Swing occupancy between empty and full so both edges are hit repeatedly.
  task automatic test_random_swings(input int n_items);
    logic [VALUE_W-1:0] pool [4];
    bit growing;
    growing = 1'b1;
    new_pool(pool);
    for (int i = 0; i < n_items; i++) begin
      if (growing && slot_value.size() >= CAPACITY && $urandom_range(0, 2) == 0) begin
        growing = 1'b0;
      end else if (!growing && slot_value.size() == 0 && $urandom_range(0, 1) == 0) begin
        growing = 1'b1;
        new_pool(pool);
      end
      random_request(growing ? 80 : 25, pool);
    end
  endtask

  // Hold the receiver off for a long stretch while items keep coming, so the input stalls.
  task automatic test_output_backpressure();
    logic [VALUE_W-1:0] pool [4];
    new_pool(pool);
    hold_request = 1'b1;
    repeat (30) random_request(60, pool);
  endtask

  // Run back-to-back with no idling on either side.
  task automatic test_full_rate(input int n_items);
    logic [VALUE_W-1:0] pool [4];
    gaps_on   = 1'b0;
    stalls_on = 1'b0;
    new_pool(pool);
    for (int i = 0; i < n_items; i++) begin
      random_request(slot_value.size() < CAPACITY / 2 ? 70 : 40, pool);
    end
  endtask

  // Receiver: random stall bursts, plus one long hold-off on request.
  initial begin
    int n;
    out_tready <= 1'b0;
    forever begin
      @(posedge clk);
      if (!rst_n) begin
        out_tready <= 1'b0;
      end else if (hold_request) begin
        hold_request = 1'b0;
        out_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        out_tready <= 1'b1;
      end else if (stalls_on && $urandom_range(0, 5) == 0) begin
        n = $urandom_range(1, 15);
        out_tready <= 1'b0;
        repeat (n) @(posedge clk);
        out_tready <= 1'b1;
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  // Compare each taken result with the oldest expectation.
  always @(posedge clk) begin
    stack_result_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_results.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= MAX_REPORTS)
          $display("unexpected result: popped_value=%0d status=%0d", out_tdata, out_tuser);
      end else begin
        want = pending_results.pop_front();
        if (out_tdata !== want.popped_value || out_tuser !== want.status) begin
          mismatch_count++;
          if (mismatch_count <= MAX_REPORTS)
            $display("mismatch: popped_value exp %0d got %0d, status exp %0d got %0d",
                     want.popped_value, out_tdata, want.status, out_tuser);
        end
      end
    end
  end

  // Guard against a hang.
  initial begin
    #4000000;
    $display("simulation failed");
    $finish;
  end

  initial begin
    rst_n          <= 1'b0;
    in_tvalid      <= 1'b0;
    in_tdata       <= '0;
    in_tuser       <= 1'b0;
    mismatch_count = 0;
    gaps_on        = 1'b1;
    stalls_on      = 1'b1;
    hold_request   = 1'b0;
    top_level      = '0;
    foreach (freq_of[i]) freq_of[i] = '0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_directed();
    test_fill_and_drain();
    test_random_swings(700);
    test_output_backpressure();
    test_full_rate(100);

    // Drop valid, then let the last results arrive within a bound.
    in_tvalid <= 1'b0;
    for (int i = 0; i < DRAIN_LIMIT && pending_results.size() != 0; i++) @(posedge clk);
    repeat (8) @(posedge clk);
    if (pending_results.size() != 0) begin
      $display("%0d results never arrived", pending_results.size());
      mismatch_count += pending_results.size();
    end
    if (mismatch_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

// File: files.f
src/mfs_pkg.sv
src/mfs_cell.sv
src/mfs_count_ram.sv
src/max_frequency_stack_unit.sv
tb/sv/max_frequency_stack_unit_tb.sv
